[rtl/core/closest_approach_collision_table_macros.svh]
// assertion macros used by the checker of the collision table
`ifndef CLOSEST_APPROACH_COLLISION_TABLE_MACROS_SVH
`define CLOSEST_APPROACH_COLLISION_TABLE_MACROS_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define CACT_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off during reset
`define CACT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/cact_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package cact_pkg;

  // table size default
  localparam int unsigned SLOTS_DEF = 32;

  // field widths
  localparam int unsigned OP_W   = 3;
  localparam int unsigned ID_W   = 16;
  localparam int unsigned POS_W  = 32;
  localparam int unsigned VEL_W  = 24;
  localparam int unsigned FT_W   = 20;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned SLOT_W = 5;
  localparam int unsigned DIST_W = 34;
  localparam int unsigned CR_W   = 24;
  localparam int unsigned ACT_W  = 6;
  localparam int unsigned PASS_W = 2;

  // configuration port
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_W     = 24;
  localparam logic [CFG_IDX_W-1:0] CFG_COLL_RANGE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_SLOTS = 1'd1;
  localparam logic [CR_W-1:0]  CR_RESET  = 24'd1024;
  localparam logic [ACT_W-1:0] ACT_RESET = 6'd20;

  // pass count saturation
  localparam logic [PASS_W-1:0] PASS_SAT = 2'd2;

  // datapath widths
  localparam int unsigned D_W     = POS_W + 1;  // line of sight component
  localparam int unsigned V_W     = VEL_W + 1;  // relative velocity component
  localparam int unsigned S_W     = 66;         // squared range
  localparam int unsigned CR2_W   = 2 * CR_W;
  localparam int unsigned VV_W    = 50;         // squared relative speed
  localparam int unsigned RDV_W   = 59;         // signed r.v
  localparam int unsigned AR_W    = 58;         // |r.v|
  localparam int unsigned MA_W    = 66;         // multiplicand
  localparam int unsigned MB_W    = 58;         // multiplier
  localparam int unsigned P_W     = 117;        // product
  localparam int unsigned RAD_W   = 68;         // square root radicand
  localparam int unsigned ROOT_W  = DIST_W;
  localparam int unsigned SREM_W  = ROOT_W + 3;
  localparam int unsigned SQC_W   = $clog2(ROOT_W + 1);
  localparam int unsigned DVC_W   = $clog2(P_W + 1);

  typedef enum logic [OP_W-1:0] {
    OP_LOAD_OWN    = 3'd0,
    OP_FRAME_START = 3'd1,
    OP_ADMIT       = 3'd2,
    OP_FRAME_END   = 3'd3,
    OP_CHECK       = 3'd4
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_SKIPPED   = 2'd3
  } status_e;

  typedef struct packed {
    logic [OP_W-1:0]         op;
    logic [ID_W-1:0]         target_id;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic signed [VEL_W-1:0] vel_x;
    logic signed [VEL_W-1:0] vel_y;
    logic signed [VEL_W-1:0] vel_z;
    logic [FT_W-1:0]         frame_time;
  } req_word_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [SLOT_W-1:0] slot;
    logic              collided;
    logic [DIST_W-1:0] distance;
    logic              by_interpolation;
  } rsp_word_t;

  typedef struct packed {
    logic [ID_W-1:0]   target;
    logic [DIST_W-1:0] range;
    logic              closing;
    logic [PASS_W-1:0] passes;
  } entry_t;

endpackage

`default_nettype wire

[rtl/core/cact_stream_if.sv]
`timescale 1ns / 1ps
`default_nettype none

// valid/ready channel carrying one word
interface cact_stream_if #(
  parameter type word_t = logic
);
  logic  valid;
  logic  ready;
  word_t word;

  modport source (output valid, output word, input ready);
  modport sink   (input valid, input word, output ready);
endinterface

`default_nettype wire

[rtl/core/closest_approach_collision_table.sv]
// load own, frame start, frame end and skipped checks: idle, then done, then the output
// admit: scan and compare for each slot scanned (up to active_slots), then done
// check: scan as admit, then a bit-serial multiplier, a square root, and on the
//   closest-approach path a divider and a second root; one item at a time
// reset: async active low, clears control, own state, slot valid bits and data registers
`timescale 1ns / 1ps
`default_nettype none

module closest_approach_collision_table import cact_pkg::*; #(
  parameter int unsigned SLOTS = SLOTS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  cact_stream_if.sink          req_i,
  cact_stream_if.source        rsp_o
);

  localparam int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CNT_W = $clog2(SLOTS + 1);
  localparam int unsigned CMP_W = (CNT_W > ACT_W) ? CNT_W : ACT_W;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_SCAN = 6'b000010,
    S_CMP  = 6'b000100,
    S_CALC = 6'b001000,
    S_WAIT = 6'b010000,
    S_DONE = 6'b100000
  } state_e;

  typedef enum logic [4:0] {
    SP_D0, SP_D1, SP_D2, SP_RNG, SP_CR, SP_V0, SP_V1, SP_V2,
    SP_R0, SP_R1, SP_R2, SP_SV, SP_AR, SP_LIM, SP_DIV, SP_DIST, SP_WB
  } step_e;

  state_e state_q;
  step_e  step_q;

  // configuration and own state
  logic [CR_W-1:0]  cr_q;
  logic [ACT_W-1:0] act_q;
  logic signed [POS_W-1:0] own_pos_q [3];
  logic signed [VEL_W-1:0] own_vel_q [3];

  // slot valid bits
  logic [SLOTS-1:0] active_q;
  logic [SLOTS-1:0] unmatched_q;
  logic [SLOTS-1:0] in_use;

  // slot memory
  entry_t mem_q [SLOTS];
  entry_t rd_q;
  logic             mem_re, mem_we;
  logic [IDX_W-1:0] rd_addr, wr_addr;
  entry_t           wr_data;

  // item and scan
  req_word_t        item_q;
  logic [CNT_W-1:0] scan_q;
  logic [CNT_W-1:0] n_w;
  logic             free_found_q;
  logic [IDX_W-1:0] free_idx_q;
  logic [IDX_W-1:0] idx_q;
  entry_t           ent_q;

  // check datapath
  logic signed [D_W-1:0] d_q [3];
  logic signed [V_W-1:0] v_q [3];
  logic [D_W-1:0]        dm [3];
  logic [V_W-1:0]        vm [3];
  logic [2:0]            neg;
  logic [S_W-1:0]        s_q;
  logic [ROOT_W-1:0]     rng_q;
  logic                  closing_q;
  logic [CR2_W-1:0]      cr2_q;
  logic [VV_W-1:0]       vv_q;
  logic signed [RDV_W-1:0] rdv_q;
  logic [AR_W-1:0]       ar;
  logic [P_W-1:0]        sv_q;
  logic [P_W-1:0]        num_q;
  logic                  hit_q, interp_q;
  logic [DIST_W-1:0]     dist_q;

  // bit-serial multiplier
  logic            mul_start;
  logic [MA_W-1:0] mul_a_d;
  logic [MB_W-1:0] mul_b_d;
  logic [P_W-1:0]  mul_a_q, mul_p_q;
  logic [MB_W-1:0] mul_b_q;

  // square root, two bits of radicand a cycle
  logic              sq_start;
  logic [RAD_W-1:0]  sq_in, sq_x_q;
  logic [SREM_W-1:0] sq_rem_q, sq_rem2, sq_trial;
  logic [ROOT_W-1:0] sq_root_q;
  logic [SQC_W-1:0]  sq_cnt_q;

  // restoring divider, one quotient bit a cycle
  logic             dv_start;
  logic [P_W-1:0]   dv_n_q;
  logic [VV_W-1:0]  dv_d_q, dv_rem_q;
  logic [VV_W:0]    dv_r2;
  logic [RAD_W-1:0] dv_q_q;
  logic [DVC_W-1:0] dv_cnt_q;

  logic             unit_done;
  logic signed [POS_W-1:0] pos_in [3];
  logic signed [VEL_W-1:0] vel_in [3];
  logic             req_fire;
  logic signed [RDV_W-1:0] rdv_term;

  // output register
  logic      rsp_valid_q;
  rsp_word_t rsp_word_q;
  rsp_word_t res_q;

  assign req_fire    = req_i.valid && req_i.ready;
  assign req_i.ready = (state_q == S_IDLE);
  assign rsp_o.valid = rsp_valid_q;
  assign rsp_o.word  = rsp_word_q;

  assign pos_in[0] = req_i.word.pos_x;
  assign pos_in[1] = req_i.word.pos_y;
  assign pos_in[2] = req_i.word.pos_z;
  assign vel_in[0] = req_i.word.vel_x;
  assign vel_in[1] = req_i.word.vel_y;
  assign vel_in[2] = req_i.word.vel_z;

  // slots in use, clamped to the table size
  always_comb begin
    logic [CMP_W-1:0] act_ext, slots_ext;
    act_ext   = CMP_W'(act_q);
    slots_ext = CMP_W'(SLOTS);
    n_w = CNT_W'((act_ext > slots_ext) ? slots_ext : act_ext);
    for (int i = 0; i < SLOTS; i++) begin
      in_use[i] = (CNT_W'(i) < n_w);
    end
  end

  // magnitudes and product signs
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      dm[k]  = d_q[k][D_W-1] ? D_W'(-d_q[k]) : D_W'(d_q[k]);
      vm[k]  = v_q[k][V_W-1] ? V_W'(-v_q[k]) : V_W'(v_q[k]);
      neg[k] = d_q[k][D_W-1] ^ v_q[k][V_W-1];
    end
    ar = rdv_q[RDV_W-1] ? AR_W'(-rdv_q) : AR_W'(rdv_q);
  end

  // memory port control
  always_comb begin
    mem_re  = (state_q == S_SCAN) && (scan_q != n_w);
    rd_addr = scan_q[IDX_W-1:0];
    mem_we  = 1'b0;
    wr_addr = idx_q;
    wr_data = '{target: item_q.target_id, range: rng_q, closing: closing_q,
                passes: (ent_q.passes < PASS_SAT) ? ent_q.passes + 2'd1 : ent_q.passes};
    if (state_q == S_SCAN && scan_q == n_w && item_q.op == OP_ADMIT && free_found_q) begin
      mem_we  = 1'b1;
      wr_addr = free_idx_q;
      wr_data = '{target: item_q.target_id, range: '0, closing: 1'b0, passes: '0};
    end else if (state_q == S_CALC && step_q == SP_WB) begin
      mem_we = 1'b1;
    end
  end

  // slot memory, one read and one write port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (mem_re) begin
      rd_q <= mem_q[rd_addr];
    end
  end

  // unit operand selection per step
  always_comb begin
    mul_a_d = '0;
    mul_b_d = '0;
    sq_in   = RAD_W'(s_q);
    case (step_q)
      SP_D0:   begin mul_a_d = MA_W'(dm[0]); mul_b_d = MB_W'(dm[0]); end
      SP_D1:   begin mul_a_d = MA_W'(dm[1]); mul_b_d = MB_W'(dm[1]); end
      SP_D2:   begin mul_a_d = MA_W'(dm[2]); mul_b_d = MB_W'(dm[2]); end
      SP_CR:   begin mul_a_d = MA_W'(cr_q);  mul_b_d = MB_W'(cr_q);  end
      SP_V0:   begin mul_a_d = MA_W'(vm[0]); mul_b_d = MB_W'(vm[0]); end
      SP_V1:   begin mul_a_d = MA_W'(vm[1]); mul_b_d = MB_W'(vm[1]); end
      SP_V2:   begin mul_a_d = MA_W'(vm[2]); mul_b_d = MB_W'(vm[2]); end
      SP_R0:   begin mul_a_d = MA_W'(dm[0]); mul_b_d = MB_W'(vm[0]); end
      SP_R1:   begin mul_a_d = MA_W'(dm[1]); mul_b_d = MB_W'(vm[1]); end
      SP_R2:   begin mul_a_d = MA_W'(dm[2]); mul_b_d = MB_W'(vm[2]); end
      SP_SV:   begin mul_a_d = MA_W'(s_q);   mul_b_d = MB_W'(vv_q);  end
      SP_AR:   begin mul_a_d = MA_W'(ar);    mul_b_d = MB_W'(ar);    end
      SP_LIM:  begin mul_a_d = MA_W'(cr2_q); mul_b_d = MB_W'(vv_q);  end
      SP_DIST: sq_in = dv_q_q;
      default: ;
    endcase
  end

  always_comb begin
    sq_start  = 1'b0;
    dv_start  = 1'b0;
    mul_start = 1'b0;
    if (state_q == S_CALC) begin
      case (step_q)
        SP_RNG, SP_DIST: sq_start = 1'b1;
        SP_DIV:          dv_start = 1'b1;
        SP_WB:           ;
        default:         mul_start = 1'b1;
      endcase
    end
    case (step_q)
      SP_RNG, SP_DIST: unit_done = (sq_cnt_q == '0);
      SP_DIV:          unit_done = (dv_cnt_q == '0);
      default:         unit_done = (mul_b_q == '0);
    endcase
  end

  // iteration datapath of the root and divider
  assign sq_rem2  = {sq_rem_q[SREM_W-3:0], sq_x_q[RAD_W-1 -: 2]};
  assign sq_trial = SREM_W'({sq_root_q, 2'b01});
  assign dv_r2    = {dv_rem_q, dv_n_q[P_W-1]};

  // shared arithmetic units
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_a_q   <= '0;
      mul_b_q   <= '0;
      mul_p_q   <= '0;
      sq_x_q    <= '0;
      sq_rem_q  <= '0;
      sq_root_q <= '0;
      sq_cnt_q  <= '0;
      dv_n_q    <= '0;
      dv_d_q    <= '0;
      dv_rem_q  <= '0;
      dv_q_q    <= '0;
      dv_cnt_q  <= '0;
    end else begin
      if (mul_start) begin
        mul_a_q <= P_W'(mul_a_d);
        mul_b_q <= mul_b_d;
        mul_p_q <= '0;
      end else if (mul_b_q != '0) begin
        if (mul_b_q[0]) begin
          mul_p_q <= mul_p_q + mul_a_q;
        end
        mul_a_q <= {mul_a_q[P_W-2:0], 1'b0};
        mul_b_q <= {1'b0, mul_b_q[MB_W-1:1]};
      end

      if (sq_start) begin
        sq_x_q    <= sq_in;
        sq_rem_q  <= '0;
        sq_root_q <= '0;
        sq_cnt_q  <= SQC_W'(ROOT_W);
      end else if (sq_cnt_q != '0) begin
        if (sq_rem2 >= sq_trial) begin
          sq_rem_q  <= sq_rem2 - sq_trial;
          sq_root_q <= {sq_root_q[ROOT_W-2:0], 1'b1};
        end else begin
          sq_rem_q  <= sq_rem2;
          sq_root_q <= {sq_root_q[ROOT_W-2:0], 1'b0};
        end
        sq_x_q   <= {sq_x_q[RAD_W-3:0], 2'b00};
        sq_cnt_q <= sq_cnt_q - SQC_W'(1);
      end

      if (dv_start) begin
        dv_n_q   <= num_q;
        dv_d_q   <= vv_q;
        dv_rem_q <= '0;
        dv_q_q   <= '0;
        dv_cnt_q <= DVC_W'(P_W);
      end else if (dv_cnt_q != '0) begin
        if (dv_r2 >= {1'b0, dv_d_q}) begin
          dv_rem_q <= VV_W'(dv_r2 - {1'b0, dv_d_q});
          dv_q_q   <= {dv_q_q[RAD_W-2:0], 1'b1};
        end else begin
          dv_rem_q <= VV_W'(dv_r2);
          dv_q_q   <= {dv_q_q[RAD_W-2:0], 1'b0};
        end
        dv_n_q   <= {dv_n_q[P_W-2:0], 1'b0};
        dv_cnt_q <= dv_cnt_q - DVC_W'(1);
      end
    end
  end

  // signed r.v term
  always_comb begin
    logic [2:0] k;
    k = 3'd0;
    case (step_q)
      SP_R1:   k = 3'd1;
      SP_R2:   k = 3'd2;
      default: k = 3'd0;
    endcase
    rdv_term = signed'(RDV_W'(mul_p_q));
    if (neg[k[1:0]]) begin
      rdv_term = -rdv_term;
    end
  end

  // control, table bits and result sequencing
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      step_q       <= SP_D0;
      cr_q         <= CR_RESET;
      act_q        <= ACT_RESET;
      for (int k = 0; k < 3; k++) begin
        own_pos_q[k] <= '0;
        own_vel_q[k] <= '0;
        d_q[k]       <= '0;
        v_q[k]       <= '0;
      end
      active_q     <= '0;
      unmatched_q  <= '0;
      item_q       <= '0;
      scan_q       <= '0;
      free_found_q <= 1'b0;
      free_idx_q   <= '0;
      idx_q        <= '0;
      ent_q        <= '0;
      s_q          <= '0;
      rng_q        <= '0;
      closing_q    <= 1'b0;
      cr2_q        <= '0;
      vv_q         <= '0;
      rdv_q        <= '0;
      sv_q         <= '0;
      num_q        <= '0;
      hit_q        <= 1'b0;
      interp_q     <= 1'b0;
      dist_q       <= '0;
      res_q        <= '0;
      rsp_valid_q  <= 1'b0;
      rsp_word_q   <= '0;
    end else begin
      // configuration writes
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_COLL_RANGE: cr_q <= cfg_wdata_i[CR_W-1:0];
          CFG_ACTIVE_SLOTS: begin
            if (cfg_wdata_i[ACT_W-1:0] != act_q) begin
              active_q    <= '0;
              unmatched_q <= '0;
            end
            act_q <= cfg_wdata_i[ACT_W-1:0];
          end
          default: ;
        endcase
      end

      // output word drains independently
      if (rsp_valid_q && rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (req_fire) begin
            item_q <= req_i.word;
            res_q  <= '0;
            state_q <= S_DONE;
            case (req_i.word.op)
              OP_LOAD_OWN: begin
                for (int k = 0; k < 3; k++) begin
                  own_pos_q[k] <= pos_in[k];
                  own_vel_q[k] <= vel_in[k];
                end
              end
              OP_FRAME_START: unmatched_q <= unmatched_q | (active_q & in_use);
              OP_FRAME_END: begin
                active_q    <= active_q & ~(in_use & unmatched_q);
                unmatched_q <= unmatched_q & ~(in_use & active_q);
              end
              OP_ADMIT: begin
                scan_q       <= '0;
                free_found_q <= 1'b0;
                free_idx_q   <= '0;
                state_q      <= S_SCAN;
              end
              OP_CHECK: begin
                if (n_w == '0 || req_i.word.frame_time == '0) begin
                  res_q.status <= ST_SKIPPED;
                end else begin
                  for (int k = 0; k < 3; k++) begin
                    d_q[k] <= D_W'(pos_in[k]) - D_W'(own_pos_q[k]);
                    v_q[k] <= V_W'(vel_in[k]) - V_W'(own_vel_q[k]);
                  end
                  scan_q  <= '0;
                  state_q <= S_SCAN;
                end
              end
              default: ;
            endcase
          end
        end

        // walk the slots in order
        S_SCAN: begin
          if (scan_q == n_w) begin
            res_q   <= '0;
            state_q <= S_DONE;
            if (item_q.op == OP_ADMIT) begin
              if (free_found_q) begin
                active_q[free_idx_q]    <= 1'b1;
                unmatched_q[free_idx_q] <= 1'b0;
                res_q.slot              <= SLOT_W'(free_idx_q);
              end else begin
                res_q.status <= ST_FULL;
              end
            end else begin
              res_q.status <= ST_NOT_FOUND;
            end
          end else begin
            state_q <= S_CMP;
          end
        end

        S_CMP: begin
          if (active_q[scan_q[IDX_W-1:0]] && rd_q.target == item_q.target_id) begin
            idx_q <= scan_q[IDX_W-1:0];
            if (item_q.op == OP_ADMIT) begin
              unmatched_q[scan_q[IDX_W-1:0]] <= 1'b0;
              res_q      <= '0;
              res_q.slot <= SLOT_W'(scan_q[IDX_W-1:0]);
              state_q    <= S_DONE;
            end else begin
              ent_q    <= rd_q;
              hit_q    <= 1'b0;
              interp_q <= 1'b0;
              dist_q   <= '0;
              step_q   <= SP_D0;
              state_q  <= S_CALC;
            end
          end else begin
            if (!active_q[scan_q[IDX_W-1:0]]) begin
              free_found_q <= 1'b1;
              free_idx_q   <= scan_q[IDX_W-1:0];
            end
            scan_q  <= scan_q + CNT_W'(1);
            state_q <= S_SCAN;
          end
        end

        // launch the unit of this step, or write back
        S_CALC: begin
          if (step_q == SP_WB) begin
            res_q <= '{status: ST_OK, slot: SLOT_W'(idx_q), collided: hit_q,
                       distance: dist_q, by_interpolation: interp_q};
            state_q <= S_DONE;
          end else begin
            state_q <= S_WAIT;
          end
        end

        // consume the unit result and choose the next step
        S_WAIT: begin
          if (unit_done) begin
            state_q <= S_CALC;
            case (step_q)
              SP_D0: begin s_q <= S_W'(mul_p_q); step_q <= SP_D1; end
              SP_D1: begin s_q <= s_q + S_W'(mul_p_q); step_q <= SP_D2; end
              SP_D2: begin s_q <= s_q + S_W'(mul_p_q); step_q <= SP_RNG; end
              SP_RNG: begin
                rng_q     <= sq_root_q;
                closing_q <= (sq_root_q < ent_q.range);
                step_q    <= SP_CR;
              end
              SP_CR: begin
                cr2_q <= mul_p_q[CR2_W-1:0];
                if (s_q <= S_W'(mul_p_q[CR2_W-1:0])) begin
                  hit_q  <= 1'b1;
                  dist_q <= rng_q;
                  step_q <= SP_WB;
                end else if (ent_q.closing && !closing_q && ent_q.passes >= PASS_SAT) begin
                  step_q <= SP_V0;
                end else begin
                  step_q <= SP_WB;
                end
              end
              SP_V0: begin vv_q <= VV_W'(mul_p_q); step_q <= SP_V1; end
              SP_V1: begin vv_q <= vv_q + VV_W'(mul_p_q); step_q <= SP_V2; end
              SP_V2: begin vv_q <= vv_q + VV_W'(mul_p_q); step_q <= SP_R0; end
              SP_R0: begin rdv_q <= rdv_term; step_q <= SP_R1; end
              SP_R1: begin rdv_q <= rdv_q + rdv_term; step_q <= SP_R2; end
              SP_R2: begin
                rdv_q  <= rdv_q + rdv_term;
                step_q <= (vv_q == '0) ? SP_WB : SP_SV;
              end
              SP_SV: begin sv_q <= mul_p_q; step_q <= SP_AR; end
              SP_AR: begin num_q <= sv_q - mul_p_q; step_q <= SP_LIM; end
              SP_LIM: begin
                if (num_q <= mul_p_q) begin
                  hit_q    <= 1'b1;
                  interp_q <= 1'b1;
                  step_q   <= SP_DIV;
                end else begin
                  step_q <= SP_WB;
                end
              end
              SP_DIV:  step_q <= SP_DIST;
              SP_DIST: begin dist_q <= sq_root_q; step_q <= SP_WB; end
              default: step_q <= SP_WB;
            endcase
          end
        end

        // hand the result to the output register
        S_DONE: begin
          if (!rsp_valid_q || rsp_o.ready) begin
            rsp_valid_q <= 1'b1;
            rsp_word_q  <= res_q;
            state_q     <= S_IDLE;
          end
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/core/cact_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

`include "closest_approach_collision_table_macros.svh"

module cact_checker import cact_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      req_valid_i,
  input logic      req_ready_i,
  input logic      rsp_valid_i,
  input logic      rsp_ready_i,
  input rsp_word_t rsp_word_i
);

  // every accepted word makes the block busy, with ready low right after it
  `CACT_ASSERT_NEXT(a_busy_after_accept, req_valid_i && req_ready_i, !req_ready_i, "ready right after accept")

  // a new result only appears while the input side is closed
  `CACT_ASSERT_SAME(a_result_from_busy, $rose(rsp_valid_i), $past(!req_ready_i), "result while idle")

  // stalled result holds
  `CACT_ASSERT_NEXT(a_rsp_hold, rsp_valid_i && !rsp_ready_i, rsp_valid_i && $stable(rsp_word_i), "stalled result changed")

  // interpolated hit is a collision of a found target
  `CACT_ASSERT_SAME(a_interp_hit, rsp_valid_i && rsp_word_i.by_interpolation, rsp_word_i.collided && (rsp_word_i.status == ST_OK), "interpolation without hit")

endmodule

bind closest_approach_collision_table cact_checker u_cact_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_i.valid),
  .req_ready_i (req_i.ready),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .rsp_word_i  (rsp_o.word)
);

`default_nettype wire

[sim/collision_table_checker.sv]
`timescale 1ns / 1ps

// watches the request and response channels, predicts every response word
// and compares it field by field with what the table returns
module collision_table_checker import cact_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  cact_stream_if               req_mon,
  cact_stream_if               rsp_mon,
  output int unsigned          fail_cnt,
  output int unsigned          pending_cnt,
  output int unsigned          result_cnt,
  output int unsigned          hit_cnt,
  output int unsigned          interp_cnt
);

  // shadow copy of registers, own state and table
  logic [CR_W-1:0]   coll_range;
  logic [ACT_W-1:0]  act_slots;
  longint            own_pos[3];
  longint            own_vel[3];
  bit                tab_active[SLOTS_DEF];
  bit                tab_unmatched[SLOTS_DEF];
  logic [ID_W-1:0]   tab_id[SLOTS_DEF];
  logic [DIST_W-1:0] tab_range[SLOTS_DEF];
  bit                tab_closing[SLOTS_DEF];
  logic [PASS_W-1:0] tab_passes[SLOTS_DEF];
  rsp_word_t         expected_q[$];

  // floor square root, saturated to the distance width
  function automatic logic [DIST_W-1:0] floor_sqrt(logic [127:0] s);
    logic [DIST_W-1:0] r;
    logic [DIST_W-1:0] t;
    r = '0;
    for (int b = DIST_W - 1; b >= 0; b--) begin
      t = r | (DIST_W'(1) << b);
      if ({94'b0, t} * {94'b0, t} <= s) r = t;
    end
    return r;
  endfunction

  function automatic void clear_table();
    for (int i = 0; i < SLOTS_DEF; i++) begin
      tab_active[i] = 1'b0;
      tab_unmatched[i] = 1'b0;
    end
  endfunction

  // next response word of the table, updating the shadow state
  function automatic rsp_word_t predict_response(req_word_t w);
    rsp_word_t         r;
    int unsigned       n, idx, free_idx;
    bit                found, free_seen, hit, interp, closing;
    longint            p[3], vl[3], d[3], v[3], rdv;
    logic [63:0]       a;
    logic [127:0]      s, cr2, vv, num, lim;
    logic [DIST_W-1:0] rng, dist_val;
    r = '0;
    n = (act_slots > SLOTS_DEF) ? SLOTS_DEF : act_slots;
    p[0] = longint'(w.pos_x);
    p[1] = longint'(w.pos_y);
    p[2] = longint'(w.pos_z);
    vl[0] = longint'(w.vel_x);
    vl[1] = longint'(w.vel_y);
    vl[2] = longint'(w.vel_z);
    found = 1'b0;
    free_seen = 1'b0;
    idx = 0;
    free_idx = 0;
    case (w.op)
      OP_LOAD_OWN: begin
        for (int k = 0; k < 3; k++) begin
          own_pos[k] = p[k];
          own_vel[k] = vl[k];
        end
      end
      OP_FRAME_START: begin
        for (int i = 0; i < n; i++) if (tab_active[i]) tab_unmatched[i] = 1'b1;
      end
      OP_FRAME_END: begin
        for (int i = 0; i < n; i++)
          if (tab_active[i] && tab_unmatched[i]) begin
            tab_active[i] = 1'b0;
            tab_unmatched[i] = 1'b0;
          end
      end
      OP_ADMIT: begin
        // scan stops at a match, last free slot before it wins otherwise
        for (int i = 0; i < n && !found; i++) begin
          if (tab_active[i] && tab_id[i] == w.target_id) begin
            found = 1'b1;
            idx = i;
          end else if (!tab_active[i]) begin
            free_seen = 1'b1;
            free_idx = i;
          end
        end
        if (found) begin
          tab_unmatched[idx] = 1'b0;
          r.slot = SLOT_W'(idx);
        end else if (!free_seen) begin
          r.status = ST_FULL;
        end else begin
          tab_id[free_idx] = w.target_id;
          tab_range[free_idx] = '0;
          tab_closing[free_idx] = 1'b0;
          tab_passes[free_idx] = '0;
          tab_unmatched[free_idx] = 1'b0;
          tab_active[free_idx] = 1'b1;
          r.slot = SLOT_W'(free_idx);
        end
      end
      OP_CHECK: begin
        if (n == 0 || w.frame_time == '0) begin
          r.status = ST_SKIPPED;
          return r;
        end
        for (int i = 0; i < n && !found; i++)
          if (tab_active[i] && tab_id[i] == w.target_id) begin
            found = 1'b1;
            idx = i;
          end
        if (!found) begin
          r.status = ST_NOT_FOUND;
          return r;
        end
        s = '0;
        vv = '0;
        rdv = 0;
        for (int k = 0; k < 3; k++) begin
          d[k] = p[k] - own_pos[k];
          v[k] = vl[k] - own_vel[k];
          a = (d[k] < 0) ? 64'(-d[k]) : 64'(d[k]);
          s += {64'b0, a} * {64'b0, a};
        end
        rng = floor_sqrt(s);
        closing = rng < tab_range[idx];
        cr2 = 128'(coll_range) * 128'(coll_range);
        hit = s <= cr2;
        interp = 1'b0;
        dist_val = hit ? rng : '0;
        // closest approach once closing has turned to opening
        if (!hit && tab_closing[idx] && !closing && tab_passes[idx] >= PASS_SAT) begin
          for (int k = 0; k < 3; k++) begin
            a = (v[k] < 0) ? 64'(-v[k]) : 64'(v[k]);
            vv += {64'b0, a} * {64'b0, a};
            rdv += d[k] * v[k];
          end
          if (vv != '0) begin
            a = (rdv < 0) ? 64'(-rdv) : 64'(rdv);
            num = s * vv - {64'b0, a} * {64'b0, a};
            lim = cr2 * vv;
            if (num <= lim) begin
              hit = 1'b1;
              interp = 1'b1;
              dist_val = floor_sqrt(num / vv);
            end
          end
        end
        tab_range[idx] = rng;
        tab_closing[idx] = closing;
        if (tab_passes[idx] < PASS_SAT) tab_passes[idx]++;
        r.slot = SLOT_W'(idx);
        r.collided = hit;
        r.distance = dist_val;
        r.by_interpolation = interp;
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  // register writes, predictions and comparisons on each edge
  always @(posedge clk_i or negedge rst_ni) begin
    rsp_word_t got, want;
    if (!rst_ni) begin
      coll_range <= CR_RESET;
      act_slots <= ACT_RESET;
      for (int k = 0; k < 3; k++) begin
        own_pos[k] = 0;
        own_vel[k] = 0;
      end
      clear_table();
      expected_q.delete();
      fail_cnt <= 0;
      pending_cnt <= 0;
      result_cnt <= 0;
      hit_cnt <= 0;
      interp_cnt <= 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_COLL_RANGE) begin
          coll_range <= cfg_wdata_i[CR_W-1:0];
        end else if (cfg_idx_i == CFG_ACTIVE_SLOTS) begin
          if (cfg_wdata_i[ACT_W-1:0] != act_slots) clear_table();
          act_slots <= cfg_wdata_i[ACT_W-1:0];
        end
      end
      if (rsp_mon.valid && rsp_mon.ready) begin
        got = rsp_mon.word;
        result_cnt <= result_cnt + 1;
        if (expected_q.size() == 0) begin
          $error("response word with nothing expected: %p", got);
          fail_cnt <= fail_cnt + 1;
        end else begin
          want = expected_q.pop_front();
          if (want.collided) hit_cnt <= hit_cnt + 1;
          if (want.by_interpolation) interp_cnt <= interp_cnt + 1;
          if (got != want) fail_cnt <= fail_cnt + 1;
          if (got.status != want.status)
            $error("status: expected %0d, got %0d", want.status, got.status);
          if (got.slot != want.slot)
            $error("slot: expected %0d, got %0d", want.slot, got.slot);
          if (got.collided != want.collided)
            $error("collided: expected %0d, got %0d", want.collided, got.collided);
          if (got.distance != want.distance)
            $error("distance: expected %0d, got %0d", want.distance, got.distance);
          if (got.by_interpolation != want.by_interpolation)
            $error("by_interpolation: expected %0d, got %0d",
                   want.by_interpolation, got.by_interpolation);
        end
      end
      if (req_mon.valid && req_mon.ready) expected_q.push_back(predict_response(req_mon.word));
      pending_cnt <= expected_q.size();
    end
  end

endmodule

[sim/tb_closest_approach_collision_table.sv]
`timescale 1ns / 1ps

module tb_closest_approach_collision_table;
  import cact_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 2000000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned TRACKS      = 8;
  localparam longint      HALF_STEP   = 32;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_wdata_i;

  cact_stream_if #(.word_t(req_word_t)) req_if ();
  cact_stream_if #(.word_t(rsp_word_t)) rsp_if ();

  int unsigned fail_cnt, pending_cnt, result_cnt, hit_cnt, interp_cnt;
  int unsigned cycle_cnt;
  int unsigned sent_cnt;
  bit          calm;
  bit          hold_req;

  // own state mirrored for building target trajectories
  longint own_p[3], own_v[3];

  // straight-line encounters: offset at closest approach, relative velocity
  logic [ID_W-1:0] track_id[TRACKS];
  longint          track_miss[TRACKS][3];
  longint          track_vrel[TRACKS][3];
  int              track_step[TRACKS];

  closest_approach_collision_table u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_if),
    .rsp_o       (rsp_if)
  );

  collision_table_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_mon     (req_if),
    .rsp_mon     (rsp_if),
    .fail_cnt    (fail_cnt),
    .pending_cnt (pending_cnt),
    .result_cnt  (result_cnt),
    .hit_cnt     (hit_cnt),
    .interp_cnt  (interp_cnt)
  );

  // clock
  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // response side: random stalls, one long hold-off on request
  initial begin
    rsp_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        rsp_if.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk_i);
      end else begin
        rsp_if.ready <= calm || ($urandom_range(0, 99) >= 11);
      end
    end
  end

  function automatic req_word_t make_word(op_e op, logic [ID_W-1:0] id, longint px,
                                          longint py, longint pz, longint vx,
                                          longint vy, longint vz, int unsigned ft);
    req_word_t w;
    w.op = op;
    w.target_id = id;
    w.pos_x = POS_W'(px);
    w.pos_y = POS_W'(py);
    w.pos_z = POS_W'(pz);
    w.vel_x = VEL_W'(vx);
    w.vel_y = VEL_W'(vy);
    w.vel_z = VEL_W'(vz);
    w.frame_time = FT_W'(ft);
    return w;
  endfunction

  // offer one word, idling at random before it, and wait for acceptance
  task automatic send_word(req_word_t w);
    if (!calm) begin
      while ($urandom_range(0, 99) < 11) begin
        req_if.valid <= 1'b0;
        @(posedge clk_i);
      end
    end
    req_if.valid <= 1'b1;
    req_if.word <= w;
    if (w.op == OP_LOAD_OWN) begin
      own_p[0] = longint'(w.pos_x);
      own_p[1] = longint'(w.pos_y);
      own_p[2] = longint'(w.pos_z);
      own_v[0] = longint'(w.vel_x);
      own_v[1] = longint'(w.vel_y);
      own_v[2] = longint'(w.vel_z);
    end
    do @(posedge clk_i); while (!req_if.ready);
    sent_cnt++;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_cnt != 0) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic longint rand_signed(int unsigned mag);
    return longint'($urandom_range(0, 2 * mag)) - longint'(mag);
  endfunction

  task automatic new_track(int t);
    track_id[t] = ID_W'($urandom);
    track_step[t] = 0;
    for (int k = 0; k < 3; k++) begin
      track_miss[t][k] = rand_signed(1500);
      track_vrel[t][k] = rand_signed(3000);
    end
  endtask

  // own load word with moderate values so targets stay within 32 bits
  task automatic send_own();
    send_word(make_word(OP_LOAD_OWN, ID_W'($urandom), rand_signed(1 << 30),
                        rand_signed(1 << 30), rand_signed(1 << 30), rand_signed(1 << 22),
                        rand_signed(1 << 22), rand_signed(1 << 22), $urandom_range(0, 1000000)));
  endtask

  // one frame: open, admit most tracks, check them, close
  task automatic run_frame();
    bit     seen[TRACKS];
    longint p[3], v[3];
    int     j;
    send_word(make_word(OP_FRAME_START, ID_W'($urandom), 0, 0, 0, 0, 0, 0, 0));
    for (int t = 0; t < TRACKS; t++) begin
      seen[t] = $urandom_range(0, 9) != 0;
      if (seen[t])
        send_word(make_word(OP_ADMIT, track_id[t], $urandom, $urandom, $urandom,
                            $urandom, $urandom, $urandom, $urandom_range(0, 1000000)));
    end
    for (int t = 0; t < TRACKS; t++) begin
      if (!seen[t]) continue;
      j = track_step[t];
      for (int k = 0; k < 3; k++) begin
        p[k] = own_p[k] + track_miss[t][k] + track_vrel[t][k] * (2 * j - 7) * HALF_STEP;
        v[k] = own_v[k] + track_vrel[t][k];
      end
      send_word(make_word(OP_CHECK, track_id[t], p[0], p[1], p[2], v[0], v[1], v[2],
                          ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 1000000)));
      track_step[t]++;
      if (track_step[t] > 8) new_track(t);
    end
    send_word(make_word(OP_FRAME_END, ID_W'($urandom), 0, 0, 0, 0, 0, 0, 0));
  endtask

  task automatic send_noise();
    req_word_t w;
    w = make_word(OP_CHECK, ID_W'($urandom), $urandom, $urandom, $urandom,
                  $urandom, $urandom, $urandom, $urandom_range(0, 1000000));
    w.op = OP_W'($urandom_range(0, 7));
    if ($urandom_range(0, 1)) w.target_id = track_id[$urandom_range(0, TRACKS - 1)];
    if (w.op == OP_LOAD_OWN) begin
      w.pos_x = POS_W'(rand_signed(1 << 30));
      w.pos_y = POS_W'(rand_signed(1 << 30));
      w.pos_z = POS_W'(rand_signed(1 << 30));
    end
    send_word(w);
  endtask

  task automatic run_phase(int unsigned items);
    int unsigned stop_at;
    stop_at = sent_cnt + items;
    send_own();
    while (sent_cnt < stop_at) begin
      if ($urandom_range(0, 3) != 0) run_frame();
      else send_noise();
    end
  endtask

  // stimulus and verdict
  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_COLL_RANGE;
    cfg_wdata_i = '0;
    req_if.valid = 1'b0;
    req_if.word = '0;
    calm = 1'b0;
    hold_req = 1'b0;
    cycle_cnt = 0;
    sent_cnt = 0;
    for (int t = 0; t < TRACKS; t++) new_track(t);
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, every op, skipped and unknown checks, freeing
    send_word(make_word(OP_LOAD_OWN, 16'hffff, 2147483647, -2147483648, 0,
                        8388607, -8388608, 0, 1000000));
    send_word(make_word(OP_ADMIT, 16'h0000, 0, 0, 0, 0, 0, 0, 0));
    send_word(make_word(OP_ADMIT, 16'hffff, -1, -1, -1, -1, -1, -1, 1));
    send_word(make_word(OP_ADMIT, 16'h0000, 0, 0, 0, 0, 0, 0, 0));
    send_word(make_word(OP_CHECK, 16'h0000, 0, 0, 0, 0, 0, 0, 0));
    send_word(make_word(OP_CHECK, 16'h1234, 0, 0, 0, 0, 0, 0, 5));
    send_word(make_word(OP_CHECK, 16'h0000, -2147483648, 2147483647, -1,
                        -8388608, 8388607, -1, 1000000));
    send_word(make_word(OP_CHECK, 16'hffff, 2147483647, -2147483648, 0,
                        8388607, -8388608, 0, 1));
    for (int k = 5; k < 8; k++) begin
      req_word_t w;
      w = make_word(OP_CHECK, 16'h0000, 0, 0, 0, 0, 0, 0, 1);
      w.op = OP_W'(k);
      send_word(w);
    end
    send_word(make_word(OP_FRAME_START, 16'h0000, 0, 0, 0, 0, 0, 0, 0));
    send_word(make_word(OP_ADMIT, 16'h0000, 0, 0, 0, 0, 0, 0, 0));
    send_word(make_word(OP_FRAME_END, 16'h0000, 0, 0, 0, 0, 0, 0, 0));
    send_word(make_word(OP_CHECK, 16'hffff, 0, 0, 0, 0, 0, 0, 1));
    send_word(make_word(OP_CHECK, 16'h0000, 0, 0, 0, 0, 0, 0, 77));

    // random phases over several register settings
    run_phase(130);
    write_reg(CFG_COLL_RANGE, '0);
    write_reg(CFG_ACTIVE_SLOTS, CFG_W'(32));
    hold_req = 1'b1;
    run_phase(130);
    write_reg(CFG_COLL_RANGE, {CFG_W{1'b1}});
    write_reg(CFG_ACTIVE_SLOTS, CFG_W'(63));
    run_phase(100);
    write_reg(CFG_COLL_RANGE, CFG_W'(3000));
    write_reg(CFG_ACTIVE_SLOTS, CFG_W'(1));
    run_phase(80);
    write_reg(CFG_ACTIVE_SLOTS, '0);
    run_phase(60);
    write_reg(CFG_COLL_RANGE, CFG_W'(1500));
    write_reg(CFG_ACTIVE_SLOTS, CFG_W'(20));
    calm = 1'b1;
    run_phase(150);
    calm = 1'b0;
    run_phase(130);

    // drain
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_cnt != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);

    $display("covered %0d request words and %0d response words over six settings",
             sent_cnt, result_cnt);
    $display("collisions seen: %0d, of them %0d at closest approach", hit_cnt, interp_cnt);
    if (fail_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
